### hdl/tosm_pkg.sv
package tosm_pkg;

   localparam int COORD_W = 16;
   localparam int DIST_W  = 50;
   localparam int SQ_W    = 34;   // dx^2 + dy^2 < 2^33
   localparam int SUM_W   = 47;   // up to 4096 terms

   typedef enum logic [1:0] {
      MODE_REF   = 2'd0,
      MODE_QUERY = 2'd1,
      MODE_CALC  = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_NONE   = 2'd1,
      STAT_SINGLE = 2'd2
   } status_type;

   // squared distance between two points: two narrow multiplies and an add
   function automatic logic [SQ_W-1:0] sq_dist(
      input logic signed [COORD_W-1:0] ax, input logic signed [COORD_W-1:0] ay,
      input logic signed [COORD_W-1:0] bx, input logic signed [COORD_W-1:0] by);
      logic signed [COORD_W:0] dx;
      logic signed [COORD_W:0] dy;
      logic [COORD_W-1:0]      mx;
      logic [COORD_W-1:0]      my;
      logic [2*COORD_W-1:0]    px;
      logic [2*COORD_W-1:0]    py;
      dx = {ax[COORD_W-1], ax} - {bx[COORD_W-1], bx};
      dy = {ay[COORD_W-1], ay} - {by[COORD_W-1], by};
      // magnitude of a 17-bit difference fits 16 unsigned bits
      mx = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
      my = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
      px = {{COORD_W{1'b0}}, mx} * {{COORD_W{1'b0}}, mx};
      py = {{COORD_W{1'b0}}, my} * {{COORD_W{1'b0}}, my};
      sq_dist = {2'b00, px} + {2'b00, py};
   endfunction

endpackage

### hdl/tosm_ram.sv
module tosm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

### hdl/tosm_div.sv
// Restoring divider, one quotient bit per cycle.
module tosm_div #(
   parameter int NUM_W = 55,
   parameter int DEN_W = 13
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quot
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quot_ff, quot_in;
   logic [DEN_W:0]   rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [DEN_W+1:0] trial;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quot_ff[NUM_W-1]} - {2'b00, den_ff};
      if (start) begin
         quot_in = num;
         rem_in  = '0;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DEN_W+1]) begin
            rem_in  = trial[DEN_W:0];
            quot_in = {quot_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in  = {rem_ff[DEN_W-1:0], quot_ff[NUM_W-1]};
            quot_in = {quot_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      if (start) begin
         den_ff <= den;
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

   property p_done_after_busy;
      @(posedge clock) disable iff (reset) done_ff |-> $past(busy_ff);
   endproperty
   a_done_after_busy: assert property (p_done_after_busy)
      else $error("divider done without work");
endmodule

### hdl/trajectory_offset_ssd_match_unit.sv
// Request with mode 0/1 appends a point to the reference/query track (busy
// stays low). Mode 2 computes: the candidate pass reads one point pair per
// cycle and writes one candidate mark per big-track offset. The sum pass skips
// each offset that is not a candidate and sums the squared distances over the
// overlap of each candidate. Then S_DIV starts the divide, S_DIVWAIT waits on
// the 55-step restoring divider (skipped with no candidate or a one-point small
// track) and S_DONE forms the result. One shared squared-distance unit serves
// both passes, fed by registered reads of the two point RAMs. The result strobe
// rsp_valid lasts one cycle and rises in the same cycle as busy falls; the
// receiver cannot stall it. Track counts are cleared once the result is out;
// candidate marks are rewritten by every candidate pass.
module trajectory_offset_ssd_match_unit #(
   parameter int MAX_POINTS = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_mode,
   input  logic signed [15:0]            req_pos_x,
   input  logic signed [15:0]            req_pos_y,
   input  logic                          csr_wr_en,
   input  logic [31:0]                   csr_wr_data,
   output logic                          rsp_valid,
   output logic [1:0]                    rsp_status,
   output logic [49:0]                   rsp_distance_q8,
   output logic [7:0]                    rsp_best_offset
);
   import tosm_pkg::*;

   localparam int AW  = $clog2(MAX_POINTS);
   localparam int CW  = $clog2(MAX_POINTS + 1);
   localparam int NUM_W = SUM_W + 8;

   typedef enum logic [2:0] {
      S_IDLE, S_CAND, S_MRD, S_SUM, S_DIV, S_DIVWAIT, S_DONE
   } state_type;

   state_type        state_ff;
   logic [31:0]      maxvar_ff;
   logic [CW-1:0]    ref_cnt_ff, qry_cnt_ff, nb_ff, ns_ff;
   logic             swap_ff;          // 1: query is the big track
   logic [CW-1:0]    k_ff, i_ff;       // loop indices
   logic             pv_ff;            // read data valid for pair (pk,pi)
   logic [CW-1:0]    pk_ff;
   logic             plast_ff;         // last term of the row
   logic             row_hit_ff;       // some pair of the row so far is close
   logic [SUM_W-1:0] sum_ff, best_ff;
   logic [CW-1:0]    bestk_ff;
   logic             found_ff;
   logic             rsp_v_ff;
   logic [1:0]       rsp_st_ff;
   logic [49:0]      rsp_d_ff;
   logic [7:0]       rsp_k_ff;

   // memories
   logic             ref_we, qry_we;
   logic [AW-1:0]    ref_wa, qry_wa, ref_ra, qry_ra, big_ra, sml_ra;
   logic [31:0]      ref_rd, qry_rd, big_rd, sml_rd;
   logic             mark_we, mark_wd, mark_rd;

   logic accept;
   assign accept = start && !busy;
   assign ref_we = accept && mode_type'(req_mode) == MODE_REF
                   && ref_cnt_ff < CW'(MAX_POINTS);
   assign qry_we = accept && mode_type'(req_mode) == MODE_QUERY
                   && qry_cnt_ff < CW'(MAX_POINTS);
   assign ref_wa = ref_cnt_ff[AW-1:0];
   assign qry_wa = qry_cnt_ff[AW-1:0];

   // address generation: candidate pass reads big[k], small[i];
   // sum pass reads big[i+k], small[i]
   logic [CW:0] bsum;
   always_comb begin
      bsum = (state_ff == S_SUM) ? ({1'b0, k_ff} + {1'b0, i_ff}) : {1'b0, k_ff};
      big_ra = bsum[AW-1:0];
      sml_ra = i_ff[AW-1:0];
      ref_ra = swap_ff ? sml_ra : big_ra;
      qry_ra = swap_ff ? big_ra : sml_ra;
      big_rd = swap_ff ? qry_rd : ref_rd;
      sml_rd = swap_ff ? ref_rd : qry_rd;
   end

   tosm_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ref (
      .clock(clock), .wr_en(ref_we), .wr_addr(ref_wa),
      .wr_data({req_pos_x, req_pos_y}), .rd_addr(ref_ra), .rd_data(ref_rd));
   tosm_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_qry (
      .clock(clock), .wr_en(qry_we), .wr_addr(qry_wa),
      .wr_data({req_pos_x, req_pos_y}), .rd_addr(qry_ra), .rd_data(qry_rd));

   // shared squared-distance unit
   logic [SQ_W-1:0] sq;
   logic            hit;
   assign sq  = sq_dist(big_rd[31:16], big_rd[15:0], sml_rd[31:16], sml_rd[15:0]);
   assign hit = sq <= {2'b00, maxvar_ff};

   // one mark per big-track offset, written at the end of its candidate row;
   // offsets at or past nb are never read, so no clearing is needed
   assign mark_we = state_ff == S_CAND && pv_ff && plast_ff;
   assign mark_wd = row_hit_ff || hit;
   tosm_ram #(.WIDTH(1), .DEPTH(MAX_POINTS)) u_mark (
      .clock(clock), .wr_en(mark_we), .wr_addr(pk_ff[AW-1:0]),
      .wr_data(mark_wd), .rd_addr(k_ff[AW-1:0]), .rd_data(mark_rd));

   // divider
   logic             div_start, div_done;
   logic [NUM_W-1:0] div_q;
   logic [CW-1:0]    den;
   assign den = ns_ff - 1'b1;
   assign div_start = state_ff == S_DIV;
   tosm_div #(.NUM_W(NUM_W), .DEN_W(CW)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .num({best_ff, 8'h00}), .den(den), .done(div_done), .quot(div_q));

   // row end tests for issue
   logic [CW:0] ik1;
   logic        row_end;
   assign ik1 = {1'b0, k_ff} + {1'b0, i_ff} + 1'b1;
   assign row_end = (i_ff + 1'b1 >= ns_ff)
                    || (state_ff == S_SUM && ik1 >= {1'b0, nb_ff});

   logic [SUM_W-1:0] nsum;
   assign nsum = sum_ff + SUM_W'(sq);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         maxvar_ff  <= 32'd36;
         ref_cnt_ff <= '0;
         qry_cnt_ff <= '0;
         pv_ff      <= 1'b0;
         row_hit_ff <= 1'b0;
         rsp_v_ff   <= 1'b0;
         found_ff   <= 1'b0;
      end else begin
         rsp_v_ff <= 1'b0;
         pv_ff    <= 1'b0;
         if (csr_wr_en) begin
            maxvar_ff <= csr_wr_data;
         end
         if (ref_we) begin
            ref_cnt_ff <= ref_cnt_ff + 1'b1;
         end
         if (qry_we) begin
            qry_cnt_ff <= qry_cnt_ff + 1'b1;
         end
         // sum pass: consume previous read
         if (pv_ff && (state_ff == S_SUM || state_ff == S_MRD)) begin
            if (plast_ff) begin
               sum_ff <= '0;
               if (!found_ff || nsum < best_ff) begin
                  found_ff <= 1'b1;
                  best_ff  <= nsum;
                  bestk_ff <= pk_ff;
               end
            end else begin
               sum_ff <= nsum;
            end
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept && mode_type'(req_mode) == MODE_CALC) begin
                  swap_ff    <= ref_cnt_ff < qry_cnt_ff;
                  nb_ff      <= (ref_cnt_ff < qry_cnt_ff) ? qry_cnt_ff : ref_cnt_ff;
                  ns_ff      <= (ref_cnt_ff < qry_cnt_ff) ? ref_cnt_ff : qry_cnt_ff;
                  k_ff       <= '0;
                  i_ff       <= '0;
                  found_ff   <= 1'b0;
                  row_hit_ff <= 1'b0;
                  sum_ff     <= '0;
                  state_ff   <= S_CAND;
               end
            end
            S_CAND: begin
               // consume previous read; the mark itself is written through u_mark
               if (pv_ff) begin
                  row_hit_ff <= !plast_ff && (row_hit_ff || hit);
               end
               if (k_ff >= nb_ff || ns_ff == '0) begin
                  if (!pv_ff) begin
                     k_ff     <= '0;
                     i_ff     <= '0;
                     state_ff <= S_MRD;
                  end
               end else begin
                  pv_ff    <= 1'b1;
                  pk_ff    <= k_ff;
                  plast_ff <= row_end;
                  if (row_end) begin
                     i_ff <= '0;
                     k_ff <= k_ff + 1'b1;
                  end else begin
                     i_ff <= i_ff + 1'b1;
                  end
               end
            end
            S_MRD: begin
               // mark of offset k is read here, valid in S_SUM
               if (k_ff >= nb_ff || ns_ff == '0) begin
                  if (!pv_ff) begin
                     state_ff <= S_DIV;
                  end
               end else begin
                  state_ff <= S_SUM;
               end
            end
            S_SUM: begin
               if (!mark_rd) begin
                  k_ff     <= k_ff + 1'b1;
                  state_ff <= S_MRD;
               end else begin
                  pv_ff    <= 1'b1;
                  pk_ff    <= k_ff;
                  plast_ff <= row_end;
                  if (row_end) begin
                     i_ff     <= '0;
                     k_ff     <= k_ff + 1'b1;
                     state_ff <= S_MRD;
                  end else begin
                     i_ff <= i_ff + 1'b1;
                  end
               end
            end
            S_DIV: begin
               if (!found_ff || ns_ff == CW'(1)) begin
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_DIVWAIT;
               end
            end
            S_DIVWAIT: begin
               if (div_done) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               rsp_v_ff <= 1'b1;
               if (!found_ff) begin
                  rsp_st_ff <= STAT_NONE;
                  rsp_d_ff  <= '0;
                  rsp_k_ff  <= '0;
               end else if (ns_ff == CW'(1)) begin
                  rsp_st_ff <= STAT_SINGLE;
                  rsp_d_ff  <= '0;
                  rsp_k_ff  <= '0;
               end else begin
                  rsp_st_ff <= STAT_OK;
                  rsp_d_ff  <= (|div_q[NUM_W-1:DIST_W]) ? {DIST_W{1'b1}}
                                                       : div_q[DIST_W-1:0];
                  rsp_k_ff  <= 8'(bestk_ff);
               end
               ref_cnt_ff <= '0;
               qry_cnt_ff <= '0;
               state_ff   <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy            = state_ff != S_IDLE;
   assign rsp_valid       = rsp_v_ff;
   assign rsp_status      = rsp_st_ff;
   assign rsp_distance_q8 = rsp_d_ff;
   assign rsp_best_offset = rsp_k_ff;

   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff |-> $past(state_ff == S_DONE))
      else $error("response without compute");
   a_idle_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff |-> (ref_cnt_ff == '0 && qry_cnt_ff == '0))
      else $error("tracks not cleared");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      ref_cnt_ff <= CW'(MAX_POINTS) && qry_cnt_ff <= CW'(MAX_POINTS))
      else $error("track count overflow");
endmodule
